// ----- hw/rtl/epd_pkg.sv -----
// Shared types and constants for the encoder position PID drive.
// No dependencies.
`timescale 1ns / 1ps
package epd_pkg;
  localparam int unsigned DutyMax  = 400;
  localparam int unsigned DegScale = 92160;

  typedef enum logic [2:0] {
    REG_TICKS  = 3'd0,
    REG_GEAR   = 3'd1,
    REG_LIM_HI = 3'd2,
    REG_LIM_LO = 3'd3,
    REG_BAND   = 3'd4,
    REG_GAIN_P = 3'd5,
    REG_GAIN_I = 3'd6,
    REG_GAIN_D = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SP, ST_CNT, ST_DIV, ST_REV, ST_ERR,
    ST_P0, ST_I0, ST_D0, ST_P1, ST_D1, ST_D2, ST_OUT, ST_HOLD
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;
endpackage

// ----- hw/rtl/epd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the count fraction.
// Depends on epd_pkg.
`timescale 1ns / 1ps
module epd_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [32:0]      num_i,
  input  logic [15:0]      den_i,
  output epd_pkg::div_ctrl_t ctrl_o,
  output logic [32:0]      quo_o
);
  import epd_pkg::*;
  logic [32:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] den_q, den_d;
  logic [16:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    den_d = den_q;
    trial = {rem_q[15:0], quo_q[32]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = 6'd33;
      den_d = (den_i == 16'd0) ? 16'd1 : den_i;
    end else if (cnt_q != 6'd0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctrl_o.start = start_i;
  assign ctrl_o.busy  = (cnt_q != 6'd0);
  assign quo_o        = quo_q;
endmodule

// ----- hw/rtl/encoder_position_pid_drive.sv -----
// Top level of the encoder position PID drive: registers, sequencer, one
// shared 33x33 multiplier and the divider. Depends on epd_pkg and epd_div.
// A wrap request is taken in the idle state and only steps the revolution count.
// A control step runs the 33-step bit-serial divider and takes nine products
// in turn from the shared multiplier; the next request can be taken in the
// cycle the result is presented, and a result not yet taken holds the step. Reset loads defaults.
`timescale 1ns / 1ps
module encoder_position_pid_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // wrap_up[0], target_angle[32:1], encoder_count[48:33], zero[55:49]
  input  logic [55:0] s_axis_tdata,
  // cmd
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // duty[8:0], turn_ccw[9], measured_angle[41:10], position_error[73:42], zero
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import epd_pkg::*;

  logic [15:0] ticks_q, gear_q;
  logic [31:0] lim_hi_q, lim_lo_q, gp_q, gi_q, gd_q;
  logic [30:0] band_q;
  logic [31:0] revs_q, e1_q, e2_q;
  logic [47:0] out_q;
  logic        inb_q;
  state_e      st_q, st_d;
  logic [31:0] tgt_q, cnt_q;
  logic signed [63:0] sp_q, meas_q;
  logic [31:0] err_q;
  logic signed [51:0] acc_q;
  logic [79:0] res_q;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [63:0] prod_q;
  logic        dstart;
  div_ctrl_t   dctl;
  logic [32:0] quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= 16'd1800; gear_q <= 16'd256;
      lim_hi_q <= 32'h7FFFFFFF; lim_lo_q <= 32'h80000000;
      band_q <= 31'd256; gp_q <= 32'd14746; gi_q <= 32'd4732; gd_q <= 32'd567;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TICKS:  ticks_q  <= cfg_data_i[15:0];
        REG_GEAR:   gear_q   <= cfg_data_i[15:0];
        REG_LIM_HI: lim_hi_q <= cfg_data_i;
        REG_LIM_LO: lim_lo_q <= cfg_data_i;
        REG_BAND:   band_q   <= cfg_data_i[30:0];
        REG_GAIN_P: gp_q     <= cfg_data_i;
        REG_GAIN_I: gi_q     <= cfg_data_i;
        REG_GAIN_D: gd_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  epd_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dstart),
    .num_i(prod_q[32:0]), .den_i(ticks_q), .ctrl_o(dctl), .quo_o(quo)
  );

  assign prod = ma * mb;

  // Multiplier operand select per state; the product is registered.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_q)
      ST_SP:  begin ma = {1'b0, cnt_q}; mb = 33'(DegScale); end
      ST_CNT, ST_DIV: begin
        ma = {tgt_q[31], tgt_q}; mb = 33'(signed'(gear_q));
      end
      ST_REV: begin ma = {revs_q[31], revs_q}; mb = 33'(DegScale); end
      ST_P0:  begin ma = {1'b0, gp_q}; mb = {err_q[31], err_q}; end
      ST_I0:  begin ma = {1'b0, gi_q}; mb = {err_q[31], err_q}; end
      ST_D0:  begin ma = {1'b0, gd_q}; mb = {err_q[31], err_q}; end
      ST_P1:  begin ma = {1'b0, gp_q}; mb = {e1_q[31], e1_q}; end
      ST_D1:  begin ma = {1'b0, gd_q}; mb = {e1_q[31], e1_q}; end
      ST_D2:  begin ma = {1'b0, gd_q}; mb = {e2_q[31], e2_q}; end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (s_axis_tvalid && !s_axis_tuser) st_d = ST_SP;
      ST_SP:   st_d = ST_CNT;
      ST_CNT:  st_d = ST_DIV;
      ST_DIV:  if (!dctl.busy && !dctl.start) st_d = ST_REV;
      ST_REV:  st_d = ST_ERR;
      ST_ERR:  st_d = ST_P0;
      ST_P0:   st_d = ST_I0;
      ST_I0:   st_d = ST_D0;
      ST_D0:   st_d = ST_P1;
      ST_P1:   st_d = ST_D1;
      ST_D1:   st_d = ST_D2;
      ST_D2:   st_d = ST_OUT;
      ST_OUT:  st_d = ST_HOLD;
      ST_HOLD: if (!m_axis_tvalid || m_axis_tready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (st_q == ST_IDLE);
    dstart        = (st_q == ST_CNT);
  end

  logic signed [63:0] sc, spc, me, ev;
  logic signed [51:0] pterm, acc_n, acc_f;
  logic [31:0] abs_e;
  logic [47:0] mag;
  logic [31:0] err_n;

  always_comb begin
    pterm = 52'(prod_q >>> 16);
    sc  = prod_q >>> 8;
    spc = sc;
    if (sc > 64'(signed'(lim_hi_q))) spc = 64'(signed'(lim_hi_q));
    else if (sc < 64'(signed'(lim_lo_q))) spc = 64'(signed'(lim_lo_q));
    me  = -(prod_q + 64'(quo));
    if (me > 64'sd2147483647) me = 64'sd2147483647;
    else if (me < -64'sd2147483648) me = -64'sd2147483648;
    ev  = sp_q - me;
    if (ev > 64'sd2147483647) ev = 64'sd2147483647;
    else if (ev < -64'sd2147483648) ev = -64'sd2147483648;
    err_n = ev[31:0];
    abs_e = err_n[31] ? 32'(-err_n) : err_n;
    acc_n = acc_q;
    acc_f = acc_q + pterm;
    mag = out_q[47] ? 48'(-out_q) : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; revs_q <= '0; e1_q <= '0; e2_q <= '0; out_q <= '0;
      inb_q <= 1'b0; m_axis_tvalid <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_IDLE && s_axis_tvalid && s_axis_tuser)
        revs_q <= s_axis_tdata[0] ? revs_q + 32'd1 : revs_q - 32'd1;
      if (st_q == ST_ERR) begin
        if (abs_e < {1'b0, band_q} && !inb_q) begin
          e1_q <= '0; e2_q <= '0; out_q <= '0; inb_q <= 1'b1;
        end else if (abs_e > {1'b0, band_q} && inb_q) begin
          inb_q <= 1'b0;
        end
      end
      if (st_q == ST_OUT) begin
        e2_q <= e1_q; e1_q <= err_q;
        if (acc_f > 52'sh7FFFFFFFFFFF) out_q <= 48'h7FFFFFFFFFFF;
        else if (acc_f < -52'sh800000000000) out_q <= 48'h800000000000;
        else out_q <= acc_f[47:0];
      end
      if (st_q == ST_HOLD && st_d == ST_IDLE) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod[63:0];
    if (st_q == ST_IDLE) begin
      tgt_q <= s_axis_tdata[32:1];
      cnt_q <= 32'(s_axis_tdata[48:33]);
    end
    if (st_q == ST_DIV) sp_q <= spc;
    if (st_q == ST_ERR) begin
      meas_q <= me;
      err_q  <= err_n;
    end
    unique case (st_q)
      ST_P0:  acc_q <= 52'(signed'(out_q));
      ST_I0, ST_D0, ST_P1: acc_q <= acc_n + pterm;
      ST_D1:  acc_q <= acc_n - pterm;
      ST_D2:  acc_q <= acc_n - pterm - pterm;
      ST_OUT: acc_q <= acc_f;
      default: ;
    endcase
    if (st_q == ST_HOLD && st_d == ST_IDLE)
      res_q <= {6'd0, err_q, meas_q[31:0], ~out_q[47],
                (mag[47:8] > 40'(DutyMax)) ? 9'(DutyMax) : mag[16:8]};
  end

  assign m_axis_tdata = res_q;

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dctl.start |=> dctl.busy) else $error("divider not started");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(st_q) == ST_HOLD) else $error("stray result");
`endif
endmodule

// ----- tb/epd_checker.sv -----
// Checker for the encoder position PID drive: it watches the request, result
// and register write ports, predicts each result and compares field by field.
// Depends on epd_pkg for the register indexes and the duty limit.
`timescale 1ns / 1ps
module epd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import epd_pkg::*;

  typedef struct {
    logic [8:0]  duty;
    logic        turn_ccw;
    logic [31:0] angle;
    logic [31:0] err;
  } drive_out_t;

  localparam longint DegPerRev = 92160;
  localparam longint I32Min = -64'sd2147483648;
  localparam longint I32Max = 64'sd2147483647;
  localparam longint O48Max = (64'sd1 <<< 47) - 1;
  localparam longint O48Min = -(64'sd1 <<< 47);

  logic [15:0] ticks_q, gear_q;
  logic [31:0] lim_hi_q, lim_lo_q, gp_q, gi_q, gd_q;
  logic [30:0] band_q;
  logic [31:0] revs_q;
  longint      e1_q, e2_q, out_q;
  logic        in_band_q;
  drive_out_t  drive_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = drive_q.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint gain_term(logic [31:0] g, longint e);
    longint gg;
    gg = longint'(g);
    return (gg * e) >>> 16;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  task automatic predict_drive(logic [31:0] target, logic [15:0] count);
    longint     sp, tk, angle, err, mag, o;
    drive_out_t r;
    sp = (longint'($signed(target)) * longint'($signed(gear_q))) >>> 8;
    if (sp > longint'($signed(lim_hi_q))) begin
      sp = longint'($signed(lim_hi_q));
    end else if (sp < longint'($signed(lim_lo_q))) begin
      sp = longint'($signed(lim_lo_q));
    end
    tk = (ticks_q == 16'd0) ? 64'sd1 : longint'(ticks_q);
    angle = -(longint'($signed(revs_q)) * DegPerRev + (longint'(count) * DegPerRev) / tk);
    angle = clip(angle, I32Min, I32Max);
    err = clip(sp - angle, I32Min, I32Max);
    mag = (err < 0) ? -err : err;
    if (mag < longint'(band_q) && !in_band_q) begin
      e1_q = 0;
      e2_q = 0;
      out_q = 0;
      in_band_q = 1'b1;
    end else if (mag > longint'(band_q) && in_band_q) begin
      in_band_q = 1'b0;
    end
    o = out_q + gain_term(gp_q, err) + gain_term(gi_q, err) + gain_term(gd_q, err)
        - gain_term(gp_q, e1_q) - 2 * gain_term(gd_q, e1_q) + gain_term(gd_q, e2_q);
    o = clip(o, O48Min, O48Max);
    out_q = o;
    e2_q = e1_q;
    e1_q = err;
    mag = ((o < 0) ? -o : o) >>> 8;
    if (mag > longint'(DutyMax)) begin
      mag = longint'(DutyMax);
    end
    r.duty     = mag[8:0];
    r.turn_ccw = (o >= 0);
    r.angle    = angle[31:0];
    r.err      = err[31:0];
    drive_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_out_t w;
    if (!rst_ni) begin
      ticks_q   <= 16'd1800;
      gear_q    <= 16'd256;
      lim_hi_q  <= 32'h7fff_ffff;
      lim_lo_q  <= 32'h8000_0000;
      band_q    <= 31'd256;
      gp_q      <= 32'd14746;
      gi_q      <= 32'd4732;
      gd_q      <= 32'd567;
      revs_q    = '0;
      e1_q      = 0;
      e2_q      = 0;
      out_q     = 0;
      in_band_q = 1'b0;
      drive_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          fails++;
        end else begin
          w = drive_q.pop_front();
          if (m_axis_tdata[8:0] !== w.duty) report("duty", m_axis_tdata[8:0], w.duty);
          if (m_axis_tdata[9] !== w.turn_ccw) report("turn_ccw", m_axis_tdata[9], w.turn_ccw);
          if (m_axis_tdata[41:10] !== w.angle) report("angle", m_axis_tdata[41:10], w.angle);
          if (m_axis_tdata[73:42] !== w.err) report("error", m_axis_tdata[73:42], w.err);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          revs_q = s_axis_tdata[0] ? revs_q + 32'd1 : revs_q - 32'd1;
        end else begin
          predict_drive(s_axis_tdata[32:1], s_axis_tdata[48:33]);
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_TICKS:  ticks_q  <= cfg_data_i[15:0];
          REG_GEAR:   gear_q   <= cfg_data_i[15:0];
          REG_LIM_HI: lim_hi_q <= cfg_data_i;
          REG_LIM_LO: lim_lo_q <= cfg_data_i;
          REG_BAND:   band_q   <= cfg_data_i[30:0];
          REG_GAIN_P: gp_q     <= cfg_data_i;
          REG_GAIN_I: gi_q     <= cfg_data_i;
          REG_GAIN_D: gd_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- tb/tb_encoder_position_pid_drive.sv -----
// Top of the encoder position PID drive testbench: clock, reset, requests,
// register settings and the verdict. Depends on epd_pkg, epd_checker and the block.
`timescale 1ns / 1ps
module tb_encoder_position_pid_drive;
  import epd_pkg::*;

  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          cycles = 0;
  bit          quiet = 1'b1;
  bit          hold_req = 1'b0;
  int          revs = 0;
  logic [15:0] cur_ticks = 16'd1800;
  logic [15:0] cur_gear = 16'd256;

  encoder_position_pid_drive dut (.*);

  epd_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls at random, and once holds off for a long stretch.
  initial begin
    int unsigned stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic send(bit cmd, bit up, logic [31:0] target, logic [15:0] count);
    int unsigned g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, count, target, up};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (cmd) revs = up ? revs + 1 : revs - 1;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_ticks = vals[REG_TICKS][15:0];
    cur_gear  = vals[REG_GEAR][15:0];
  endtask

  task automatic random_item();
    int unsigned r;
    logic [31:0] target;
    logic [15:0] count;
    longint      tk, angle;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) count = 16'($urandom);
    else count = 16'($urandom_range(0, (cur_ticks == 0) ? 0 : cur_ticks - 1));
    if (r < 15) begin
      send(1'b1, 1'($urandom_range(0, 1)), $urandom, 16'($urandom));
      return;
    end
    case ($urandom_range(0, 3))
      0: target = $urandom;
      1: target = 32'($urandom_range(0, 400000)) - 32'd200000;
      2: begin
        tk = (cur_ticks == 0) ? 1 : longint'(cur_ticks);
        angle = -(longint'(revs) * 92160 + (longint'(count) * 92160) / tk);
        target = (cur_gear == 16'd256)
                 ? 32'(angle + longint'($urandom_range(0, 600)) - 300)
                 : 32'($urandom_range(0, 2000)) - 32'd1000;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: target = 32'h7fff_ffff;
          1: target = 32'h8000_0000;
          default: target = '0;
        endcase
      end
    endcase
    send(1'b0, 1'($urandom_range(0, 1)), target, count);
  endtask

  initial begin
    logic [31:0] cfgs[6][8];
    cfgs[0] = '{32'd1800, 32'd256, 32'h7fff_ffff, 32'h8000_0000, 32'd256,
                32'd14746, 32'd4732, 32'd567};
    cfgs[1] = '{32'd0, 32'd256, 32'd50000, -32'sd50000, 32'd0,
                32'hffff_ffff, 32'd0, 32'hffff_ffff};
    cfgs[2] = '{32'd65535, 32'h0000_8000, -32'sd1000, 32'd1000, 32'h7fff_ffff,
                32'd0, 32'hffff_ffff, 32'd0};
    cfgs[3] = '{32'd1, 32'd32767, 32'h7fff_ffff, 32'h8000_0000, 32'd1000,
                32'd65536, 32'd65536, 32'd65536};
    cfgs[4] = '{32'd360, 32'd256, 32'd100000, -32'sd100000, 32'd5000,
                $urandom, $urandom, $urandom};
    cfgs[5] = '{$urandom_range(1, 65535), $urandom, $urandom, $urandom,
                $urandom_range(0, 20000), $urandom, $urandom, $urandom};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset settings.
    send(1'b0, 1'b0, 32'd0, 16'd0);
    send(1'b0, 1'b0, 32'd0, 16'd0);
    send(1'b0, 1'b0, 32'd256, 16'd0);
    send(1'b0, 1'b0, 32'd300, 16'd0);
    send(1'b0, 1'b1, 32'h7fff_ffff, 16'd0);
    send(1'b0, 1'b0, 32'h8000_0000, 16'd1799);
    send(1'b0, 1'b1, 32'hffff_ffff, 16'hffff);
    send(1'b1, 1'b1, 32'hffff_ffff, 16'hffff);
    send(1'b1, 1'b1, 32'd0, 16'd0);
    send(1'b1, 1'b1, 32'd0, 16'd0);
    send(1'b0, 1'b0, -32'sd276480, 16'd0);
    repeat (5) send(1'b1, 1'b0, 32'd0, 16'd0);
    send(1'b0, 1'b0, 32'd184320, 16'd0);
    send(1'b0, 1'b0, 32'h5555_5555, 16'haaaa);
    send(1'b0, 1'b1, 32'haaaa_aaaa, 16'h5555);
    send(1'b0, 1'b0, 32'd0, 16'd900);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_regs(cfgs[p]);
      quiet = (p % 3 == 0);
      if (p == 2) hold_req = 1'b1;
      repeat (72) random_item();
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- encoder_position_pid_drive.f -----
hw/rtl/epd_pkg.sv
hw/rtl/epd_div.sv
hw/rtl/encoder_position_pid_drive.sv
tb/epd_checker.sv
tb/tb_encoder_position_pid_drive.sv
